[rtl/dfa_pkg.sv]
// Shared constants, codes and types of the table-driven DFA engine.
package dfa_pkg;

   localparam int NUM_STATES  = 64;
   localparam int SYMBOL_BITS = 8;

   localparam int NSYM        = 1 << SYMBOL_BITS;
   localparam int STATE_BITS  = $clog2(NUM_STATES);
   localparam int ENTRY_W     = STATE_BITS + 1;
   localparam int TRANS_DEPTH = NUM_STATES * NSYM;
   localparam int TRANS_AW    = $clog2(TRANS_DEPTH);

   localparam int FUNC_W      = 3;
   localparam int STATE_IN_W  = 6;
   localparam int SYM_W       = 8;
   localparam int CUR_W       = 7;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_STEP    = 3'd0,
      FUNC_ADD     = 3'd1,
      FUNC_MARK    = 3'd2,
      FUNC_QUERY   = 3'd3,
      FUNC_RESTART = 3'd4
   } func_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

endpackage

[rtl/dfa_req_if.sv]
// Request channel: one operation beat.
interface dfa_req_if;
   import dfa_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [FUNC_W-1:0]     func;
   logic [STATE_IN_W-1:0] src_state;
   logic [SYM_W-1:0]      symbol;
   logic [STATE_IN_W-1:0] dst_state;

   modport source (output valid, func, src_state, symbol, dst_state, input ready);
   modport sink   (input valid, func, src_state, symbol, dst_state, output ready);
endinterface

[rtl/dfa_rsp_if.sv]
// Response channel: one result beat.
interface dfa_rsp_if;
   import dfa_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [CUR_W-1:0] current;
   logic                    final_flag;
   logic                    status;

   modport source (output valid, current, final_flag, status, input ready);
   modport sink   (input valid, current, final_flag, status, output ready);
endinterface

[rtl/dfa_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module dfa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

[rtl/table_driven_dfa_engine.sv]
// Top level of the table-driven DFA engine: transition RAM, accept RAM, control.
//
//   channel   dir   ports     beat
//   request   in    req_bus   func, src_state, symbol, dst_state
//   response  out   rsp_bus   current, final_flag, status
//
// For each request the accept cycle issues the RAM reads and the next cycle
// evaluates the read data and writes back. One request is in work at a time.
// After reset a clearing pass over TRANS_DEPTH (16384) entries zeroes both RAMs;
// req_bus.ready stays low until it ends. A response waiting in the output
// register does not block a new request if it is taken in the same cycle.
module table_driven_dfa_engine (
   input  logic  clock,
   input  logic  reset,
   dfa_req_if.sink   req_bus,
   dfa_rsp_if.source rsp_bus
);
   import dfa_pkg::*;

   function automatic logic [TRANS_AW-1:0] trans_addr(input logic [31:0] st,
                                                       input logic [SYM_W-1:0] sym);
      return TRANS_AW'((st << SYMBOL_BITS) + 32'(sym));
   endfunction

   state_type             state_ff, state_in;
   logic [TRANS_AW-1:0]   clr_cnt_ff, clr_cnt_in;
   logic [NUM_STATES-1:0] known_ff, known_in;
   logic [STATE_BITS-1:0] cur_ff, cur_in;
   logic                  dead_ff, dead_in;

   logic [FUNC_W-1:0]     func_ff;
   logic [STATE_IN_W-1:0] src_ff, dst_ff;
   logic [SYM_W-1:0]      sym_ff;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [CUR_W-1:0] rsp_current_ff, rsp_current_in;
   logic                    rsp_final_ff, rsp_final_in;
   logic                    rsp_status_ff, rsp_status_in;

   logic                  req_take;

   logic                  trans_we;
   logic [TRANS_AW-1:0]   trans_waddr, trans_raddr;
   logic [ENTRY_W-1:0]    trans_wdata, trans_rdata;
   logic                  acc_we;
   logic [STATE_BITS-1:0] acc_waddr, acc_raddr;
   logic                  acc_wdata, acc_rdata;

   logic                  src_ok, dst_ok, sym_ok;
   logic [STATE_BITS-1:0] src_idx, dst_idx;
   logic                  exec_done;

   dfa_ram #(.WIDTH(ENTRY_W), .DEPTH(TRANS_DEPTH)) u_trans_ram (
      .clock (clock),
      .we    (trans_we),
      .waddr (trans_waddr),
      .wdata (trans_wdata),
      .raddr (trans_raddr),
      .rdata (trans_rdata)
   );

   dfa_ram #(.WIDTH(1), .DEPTH(NUM_STATES)) u_acc_ram (
      .clock (clock),
      .we    (acc_we),
      .waddr (acc_waddr),
      .wdata (acc_wdata),
      .raddr (acc_raddr),
      .rdata (acc_rdata)
   );

   assign req_bus.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_bus.ready);
   assign req_take      = req_bus.valid && req_bus.ready;

   // Reads are issued straight from the request beat; data lands in ST_EXEC.
   assign trans_raddr = (func_type'(req_bus.func) == FUNC_STEP) ?
                        trans_addr(32'(cur_ff), req_bus.symbol) :
                        trans_addr(32'(req_bus.src_state), req_bus.symbol);
   assign acc_raddr   = STATE_BITS'(req_bus.src_state);

   assign src_ok  = 32'(src_ff) < NUM_STATES;
   assign dst_ok  = 32'(dst_ff) < NUM_STATES;
   assign sym_ok  = 32'(sym_ff) < NSYM;
   assign src_idx = STATE_BITS'(src_ff);
   assign dst_idx = STATE_BITS'(dst_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_cnt_ff == TRANS_AW'(TRANS_DEPTH - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_take) state_in = ST_EXEC;
         end
         ST_EXEC: state_in = ST_IDLE;
         default: state_in = ST_CLEAR;
      endcase
   end

   // datapath and RAM controls
   always_comb begin
      clr_cnt_in     = clr_cnt_ff;
      known_in       = known_ff;
      cur_in         = cur_ff;
      dead_in        = dead_ff;
      trans_we       = 1'b0;
      trans_waddr    = trans_addr(32'(src_ff), sym_ff);
      trans_wdata    = {1'b1, dst_idx};
      acc_we         = 1'b0;
      acc_waddr      = src_idx;
      acc_wdata      = 1'b1;
      exec_done      = 1'b0;
      rsp_final_in   = 1'b0;
      rsp_status_in  = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in  = clr_cnt_ff + TRANS_AW'(1);
            trans_we    = 1'b1;
            trans_waddr = clr_cnt_ff;
            trans_wdata = '0;
            acc_we      = 32'(clr_cnt_ff) < NUM_STATES;
            acc_waddr   = STATE_BITS'(clr_cnt_ff);
            acc_wdata   = 1'b0;
         end
         ST_EXEC: begin
            exec_done = 1'b1;
            case (func_type'(func_ff))
               FUNC_STEP: begin
                  if (!dead_ff && sym_ok && trans_rdata[ENTRY_W-1]) begin
                     cur_in = trans_rdata[STATE_BITS-1:0];
                  end else begin
                     dead_in = 1'b1;
                  end
               end
               FUNC_ADD: begin
                  if (src_ok && dst_ok && sym_ok) begin
                     known_in[src_idx] = 1'b1;
                     known_in[dst_idx] = 1'b1;
                     // first insert wins
                     trans_we = !trans_rdata[ENTRY_W-1];
                  end
               end
               FUNC_MARK: begin
                  if (src_ok && known_ff[src_idx]) begin
                     acc_we = 1'b1;
                  end else begin
                     rsp_status_in = 1'b1;
                  end
               end
               FUNC_QUERY: begin
                  if (src_ok && known_ff[src_idx]) begin
                     rsp_final_in = acc_rdata;
                  end else begin
                     rsp_status_in = 1'b1;
                  end
               end
               FUNC_RESTART: begin
                  cur_in  = '0;
                  dead_in = 1'b0;
               end
               default: ;
            endcase
         end
         default: ;
      endcase
      rsp_current_in = dead_in ? '1 : CUR_W'(cur_in);
      rsp_valid_in   = exec_done || (rsp_valid_ff && !rsp_bus.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         known_ff     <= '0;
         cur_ff       <= '0;
         dead_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         known_ff     <= known_in;
         cur_ff       <= cur_in;
         dead_ff      <= dead_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         func_ff <= req_bus.func;
         src_ff  <= req_bus.src_state;
         sym_ff  <= req_bus.symbol;
         dst_ff  <= req_bus.dst_state;
      end
      if (exec_done) begin
         rsp_current_ff <= rsp_current_in;
         rsp_final_ff   <= rsp_final_in;
         rsp_status_ff  <= rsp_status_in;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.current    = rsp_current_ff;
   assign rsp_bus.final_flag = rsp_final_ff;
   assign rsp_bus.status     = rsp_status_ff;
endmodule

[tb/table_driven_dfa_engine_test.sv]
// Testbench for the table-driven DFA engine: stimulus, shadow automaton and checks.
module table_driven_dfa_engine_test;
   timeunit 1ns;
   timeprecision 1ps;
   import dfa_pkg::*;

   localparam int RANDOM_OPS  = 1800;
   localparam int QUIET_TAIL  = 200;
   localparam int HOLD_AT     = 400;
   localparam int HOLD_CYCLES = 80;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic signed [CUR_W-1:0] current;
      logic                    final_flag;
      logic                    status;
   } answer_type;

   // Shadow copy of the automaton; predicts one answer per accepted beat.
   class dfa_tracker;
      bit                    arc_valid [NUM_STATES][NSYM];
      logic [STATE_BITS-1:0] arc_target [NUM_STATES][NSYM];
      bit                    known [NUM_STATES];
      bit                    accepting [NUM_STATES];
      bit                    dead;
      logic [STATE_BITS-1:0] walk_state;
      answer_type            pending_answers[$];
      int                    mismatches;

      function new();
         dead = 1'b0;
         walk_state = '0;
         mismatches = 0;
      endfunction

      function void apply_op(logic [FUNC_W-1:0] f, logic [STATE_IN_W-1:0] src,
                             logic [SYM_W-1:0] sym, logic [STATE_IN_W-1:0] dst);
         answer_type a;
         a.final_flag = 1'b0;
         a.status = 1'b0;
         case (f)
            FUNC_STEP: begin
               if (!dead && arc_valid[walk_state][sym])
                  walk_state = arc_target[walk_state][sym];
               else
                  dead = 1'b1;
            end
            FUNC_ADD: begin
               if (!known[dst]) begin
                  known[dst] = 1'b1;
                  accepting[dst] = 1'b0;
               end
               if (!known[src]) begin
                  known[src] = 1'b1;
                  accepting[src] = 1'b0;
               end
               // first insert wins
               if (!arc_valid[src][sym]) begin
                  arc_valid[src][sym] = 1'b1;
                  arc_target[src][sym] = dst;
               end
            end
            FUNC_MARK: begin
               if (known[src]) accepting[src] = 1'b1;
               else a.status = 1'b1;
            end
            FUNC_QUERY: begin
               if (known[src]) a.final_flag = accepting[src];
               else a.status = 1'b1;
            end
            FUNC_RESTART: begin
               dead = 1'b0;
               walk_state = '0;
            end
            default: ;
         endcase
         a.current = dead ? -7'sd1 : $signed({1'b0, walk_state});
         pending_answers.push_back(a);
      endfunction

      task report(string msg);
         $display("mismatch: %s", msg);
         mismatches++;
      endtask

      task check_response(logic signed [CUR_W-1:0] cur, logic fin, logic st);
         answer_type want;
         if (pending_answers.size() == 0) begin
            report($sformatf("response with nothing pending, current=%0d", cur));
            return;
         end
         want = pending_answers.pop_front();
         if (cur !== want.current)
            report($sformatf("current %0d, expected %0d", cur, want.current));
         if (fin !== want.final_flag)
            report($sformatf("final_flag %b, expected %b", fin, want.final_flag));
         if (st !== want.status)
            report($sformatf("status %b, expected %b", st, want.status));
      endtask

      function int pending();
         return pending_answers.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   int   sent;
   int   cycle_count = 0;
   bit   quiet;
   bit   hold_given = 1'b0;

   dfa_tracker tracker = new();

   dfa_req_if req_bus();
   dfa_rsp_if rsp_bus();

   table_driven_dfa_engine u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         tracker.check_response(rsp_bus.current, rsp_bus.final_flag, rsp_bus.status);
   end

   // Receiver: random stall bursts, one long hold-off, none near the end.
   initial begin
      rsp_bus.ready <= 1'b0;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         if (!hold_given && sent >= HOLD_AT) begin
            hold_given = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
      end
   end

   task automatic issue_op(logic [FUNC_W-1:0] f, logic [STATE_IN_W-1:0] src,
                           logic [SYM_W-1:0] sym, logic [STATE_IN_W-1:0] dst);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.func      <= f;
      req_bus.src_state <= src;
      req_bus.symbol    <= sym;
      req_bus.dst_state <= dst;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      tracker.apply_op(f, src, sym, dst);
      sent++;
   endtask

   function automatic logic [STATE_IN_W-1:0] rand_state();
      return STATE_IN_W'($urandom_range(0, 63));
   endfunction

   function automatic logic [SYM_W-1:0] rand_sym();
      return SYM_W'($urandom_range(0, 255));
   endfunction

   // Mostly a small pool of states and symbols so walks find real arcs.
   function automatic logic [STATE_IN_W-1:0] pick_state();
      if ($urandom_range(0, 6) != 0) return STATE_IN_W'($urandom_range(0, 7));
      return rand_state();
   endfunction

   function automatic logic [SYM_W-1:0] pick_sym();
      logic [SYM_W-1:0] alphabet [4] = '{8'h00, 8'h61, 8'h62, 8'hFF};
      if ($urandom_range(0, 6) != 0) return alphabet[2'($urandom_range(0, 3))];
      return rand_sym();
   endfunction

   task automatic build_burst();
      int n;
      n = $urandom_range(2, 8);
      repeat (n) begin
         if ($urandom_range(0, 4) == 0)
            issue_op(FUNC_MARK, pick_state(), rand_sym(), rand_state());
         else
            issue_op(FUNC_ADD, pick_state(), pick_sym(), pick_state());
      end
   endtask

   task automatic walk_burst();
      int n;
      n = $urandom_range(3, 12);
      issue_op(FUNC_RESTART, rand_state(), rand_sym(), rand_state());
      repeat (n) begin
         if ($urandom_range(0, 4) == 0)
            issue_op(FUNC_QUERY, pick_state(), rand_sym(), rand_state());
         else
            issue_op(FUNC_STEP, rand_state(), pick_sym(), rand_state());
      end
   endtask

   initial begin
      int total;
      int pick;
      reset <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.func      <= '0;
      req_bus.src_state <= '0;
      req_bus.symbol    <= '0;
      req_bus.dst_state <= '0;
      sent = 0;
      quiet = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: unknown states, dead state, duplicates, self-loop on a new state, unused func codes
      issue_op(FUNC_QUERY, 6'd0, 8'h00, 6'd0);
      issue_op(FUNC_MARK, 6'd63, 8'h00, 6'd0);
      issue_op(FUNC_STEP, 6'd0, 8'hFF, 6'd0);
      issue_op(FUNC_STEP, 6'd0, 8'h00, 6'd0);
      issue_op(FUNC_RESTART, 6'd0, 8'h00, 6'd0);
      issue_op(FUNC_ADD, 6'd0, 8'hFF, 6'd63);
      issue_op(FUNC_ADD, 6'd63, 8'h00, 6'd63);
      issue_op(FUNC_ADD, 6'd0, 8'hFF, 6'd5);
      issue_op(FUNC_QUERY, 6'd5, 8'h00, 6'd0);
      issue_op(FUNC_MARK, 6'd63, 8'h00, 6'd0);
      issue_op(FUNC_ADD, 6'd63, 8'h01, 6'd0);
      issue_op(FUNC_QUERY, 6'd63, 8'h00, 6'd0);
      issue_op(FUNC_STEP, 6'd0, 8'hFF, 6'd0);
      issue_op(FUNC_STEP, 6'd0, 8'h00, 6'd0);
      issue_op(FUNC_STEP, 6'd0, 8'h55, 6'd0);
      issue_op(FUNC_STEP, 6'd0, 8'h01, 6'd0);
      issue_op(FUNC_ADD, 6'd42, 8'hAA, 6'd42);
      issue_op(FUNC_ADD, 6'd0, 8'h2A, 6'd42);
      issue_op(FUNC_RESTART, 6'd63, 8'hFF, 6'd63);
      issue_op(FUNC_STEP, 6'd0, 8'h2A, 6'd0);
      issue_op(FUNC_STEP, 6'd0, 8'hAA, 6'd0);
      issue_op(3'd5, 6'd63, 8'hFF, 6'd63);
      issue_op(3'd6, 6'd21, 8'h55, 6'd42);
      issue_op(3'd7, 6'd42, 8'hAA, 6'd21);
      issue_op(FUNC_MARK, 6'd42, 8'h00, 6'd0);
      issue_op(FUNC_QUERY, 6'd42, 8'h00, 6'd0);

      total = sent + RANDOM_OPS;
      while (sent < total) begin
         if (sent >= total - QUIET_TAIL) quiet = 1'b1;
         pick = $urandom_range(0, 9);
         if (pick < 4)
            build_burst();
         else if (pick < 9)
            walk_burst();
         else
            issue_op(FUNC_W'($urandom_range(0, 7)), rand_state(), rand_sym(), rand_state());
      end
      req_bus.valid <= 1'b0;

      while (tracker.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.pending() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule

[files.f]
rtl/dfa_pkg.sv
rtl/dfa_req_if.sv
rtl/dfa_rsp_if.sv
rtl/dfa_ram.sv
rtl/table_driven_dfa_engine.sv
tb/table_driven_dfa_engine_test.sv
